// ===== hdl/lasa_pkg.sv =====
// Shared types, constants and arithmetic helpers for the affine-gap local alignment block.
package lasa_pkg;

    localparam int unsigned MAX_QUERY_DEF   = 64;
    localparam int unsigned SYMBOL_BITS_DEF = 4;

    localparam int unsigned SYMBOL_FIELD_W = 4;
    localparam int unsigned SCORE_OUT_W    = 15;
    localparam int unsigned S_TDATA_W      = 8;
    localparam int unsigned M_TDATA_W      = 16;
    localparam int unsigned APB_ADDR_W     = 4;
    localparam int unsigned APB_DATA_W     = 32;
    localparam int unsigned WIDE_W         = 18;

    localparam logic [7:0] GAP_OPEN_RST   = 8'd33;
    localparam logic [7:0] GAP_EXTEND_RST = 8'd7;
    localparam logic [6:0] MATCH_RST      = 7'd10;
    localparam logic [7:0] MISMATCH_RST   = 8'hF1;

    typedef enum logic [1:0] {
        REG_GAP_OPEN   = 2'd0,
        REG_GAP_EXTEND = 2'd1,
        REG_MATCH      = 2'd2,
        REG_MISMATCH   = 2'd3
    } reg_idx_t;

    typedef logic signed [15:0]       score_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic [7:0]        open_pen;
        logic [7:0]        gap_ext;
        logic [6:0]        match;
        logic signed [7:0] mismatch;
        logic [8:0]        open_ext;
    } cfg_t;

    // one database symbol travelling along the row of cells
    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic                      last;
        logic [SYMBOL_FIELD_W-1:0] dsym;
        score_t                    left;
        score_t                    qgap;
        score_t                    diag;
        score_t                    best;
    } token_t;

    function automatic score_t clamp16(input wide_t v);
        score_t r;
        if (v > wide_t'(32767)) begin
            r = 16'sd32767;
        end else if (v < -wide_t'(32768)) begin
            r = -16'sd32768;
        end else begin
            r = score_t'(v);
        end
        return r;
    endfunction

    function automatic wide_t wmax(input wide_t a, input wide_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic score_t smax(input score_t a, input score_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hdl/local_alignment_score_affine.sv =====
// Top level: query loading, systolic row of cells and the result stage.
//
//  channel   ports                         fields (low bit up)
//  input     s_tvalid/s_tready             s_tuser=req_type, s_tdata=symbol, s_tlast=last
//  result    m_tvalid/m_tready             m_tdata=score
//  config    psel/penable/pwrite/paddr     open, extend, match, mismatch at 4*i
//
// A database symbol enters the cell row every cycle and moves one cell a cycle,
// both while no held result stalls the row; its result passes each cell's token
// register, then the result register. A query symbol is taken only once the row
// holds no transaction, so the first query symbol after database work waits for
// the row to drain, longer while a result stalls; then one per cycle.
// Reset is synchronous; cell contents need none, the first-symbol flag clears them.
// A held result with m_tready low freezes the whole row and stops database input.
module local_alignment_score_affine import lasa_pkg::*; #(
    parameter int unsigned MAX_QUERY   = MAX_QUERY_DEF,
    parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] symbol
    input  logic                  s_tuser,   // [0] req_type
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [14:0] score
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned LEN_W = $clog2(MAX_QUERY + 1);
    localparam int unsigned CMP_W = (SYMBOL_BITS < SYMBOL_FIELD_W) ? SYMBOL_BITS
                                                                    : SYMBOL_FIELD_W;

    cfg_t cfg;

    logic [LEN_W-1:0] qlen_reg, qlen_next;
    logic             loading_reg, loading_next;
    logic             row_active_reg, row_active_next;
    logic [LEN_W-1:0] inflight_reg, inflight_next;
    score_t           acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;
    logic [SCORE_OUT_W-1:0] out_score_reg, out_score_next;

    logic             advance;
    logic             db_acc;
    logic             q_acc;
    logic [LEN_W-1:0] wr_base;
    logic             wr_valid;
    logic             tail_take;
    score_t           tail_best;

    token_t tok [0:MAX_QUERY];
    token_t tail;

    lasa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = s_tuser ? advance : (inflight_reg == '0);
    assign db_acc   = s_tvalid && s_tready && s_tuser;
    assign q_acc    = s_tvalid && s_tready && !s_tuser;

    // a query symbol after a closed query starts a new one
    assign wr_base  = loading_reg ? qlen_reg : '0;
    assign wr_valid = q_acc && (wr_base < LEN_W'(MAX_QUERY));

    assign tok[0] = '{
        valid: db_acc,
        first: !row_active_reg,
        last:  s_tlast,
        dsym:  s_tdata[SYMBOL_FIELD_W-1:0],
        left:  '0,
        qgap:  -score_t'({1'b0, cfg.open_pen}),
        diag:  '0,
        best:  '0
    };

    for (genvar k = 0; k < MAX_QUERY; k++) begin : g_cell
        lasa_cell #(
            .INDEX (k),
            .LEN_W (LEN_W),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cfg      (cfg),
            .wr_valid (wr_valid),
            .wr_idx   (wr_base),
            .wr_sym   (s_tdata[SYMBOL_FIELD_W-1:0]),
            .qlen     (qlen_reg),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1])
        );
    end

    assign tail      = tok[MAX_QUERY];
    assign tail_take = advance && tail.valid;
    assign tail_best = tail.first ? tail.best : smax(acc_reg, tail.best);

    always_comb begin
        qlen_next       = qlen_reg;
        loading_next    = loading_reg;
        row_active_next = row_active_reg;
        if (q_acc) begin
            qlen_next    = wr_valid ? wr_base + LEN_W'(1) : wr_base;
            loading_next = !s_tlast;
            if (!loading_reg) begin
                row_active_next = 1'b0;
            end
        end else if (db_acc) begin
            loading_next    = 1'b0;
            row_active_next = !s_tlast;
        end
    end

    always_comb begin
        inflight_next = inflight_reg;
        if (db_acc && !tail_take) begin
            inflight_next = inflight_reg + LEN_W'(1);
        end else if (!db_acc && tail_take) begin
            inflight_next = inflight_reg - LEN_W'(1);
        end
    end

    always_comb begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_score_next = out_score_reg;
        if (tail_take) begin
            acc_next = tail_best;
        end
        if (tail_take && tail.last) begin
            out_valid_next = 1'b1;
            out_score_next = tail_best[SCORE_OUT_W-1:0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlen_reg       <= '0;
            loading_reg    <= 1'b1;
            row_active_reg <= 1'b0;
            inflight_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            qlen_reg       <= qlen_next;
            loading_reg    <= loading_next;
            row_active_reg <= row_active_next;
            inflight_reg   <= inflight_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        out_score_reg <= out_score_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SCORE_OUT_W){1'b0}}, out_score_reg};

endmodule

// ===== hdl/lasa_regs.sv =====
// APB register file holding the gap penalties and substitution scores.
module lasa_regs import lasa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [7:0] open_pen_reg;
    logic [7:0] gap_ext_reg;
    logic [6:0] match_reg;
    logic [7:0] mismatch_reg;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_pen_reg <= GAP_OPEN_RST;
            gap_ext_reg  <= GAP_EXTEND_RST;
            match_reg    <= MATCH_RST;
            mismatch_reg <= MISMATCH_RST;
        end else if (wr_en) begin
            case (idx)
                REG_GAP_OPEN:   open_pen_reg <= pwdata[7:0];
                REG_GAP_EXTEND: gap_ext_reg  <= pwdata[7:0];
                REG_MATCH:      match_reg    <= pwdata[6:0];
                REG_MISMATCH:   mismatch_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GAP_OPEN:   prdata = {24'd0, open_pen_reg};
            REG_GAP_EXTEND: prdata = {24'd0, gap_ext_reg};
            REG_MATCH:      prdata = {25'd0, match_reg};
            REG_MISMATCH:   prdata = {24'd0, mismatch_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.open_pen = open_pen_reg;
    assign cfg.gap_ext  = gap_ext_reg;
    assign cfg.match    = match_reg;
    assign cfg.mismatch = $signed(mismatch_reg);
    assign cfg.open_ext = {1'b0, open_pen_reg} + {1'b0, gap_ext_reg};

endmodule

// ===== hdl/lasa_cell.sv =====
// One query cell: holds a query symbol and its column state, applies the Gotoh update.
module lasa_cell import lasa_pkg::*; #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned LEN_W = 7,
    parameter int unsigned CMP_W = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  cfg_t                      cfg,
    input  logic                      wr_valid,
    input  logic [LEN_W-1:0]          wr_idx,
    input  logic [SYMBOL_FIELD_W-1:0] wr_sym,
    input  logic [LEN_W-1:0]          qlen,
    input  token_t                    tok_in,
    output token_t                    tok_out
);

    logic [CMP_W-1:0] qsym_reg;
    score_t           h_reg;
    score_t           e_reg;
    token_t           tok_reg;
    token_t           tok_next;

    logic   active;
    wide_t  ext_w;
    wide_t  oe_w;
    wide_t  sub_w;
    score_t h_cur;
    score_t e_cur;
    score_t qgap_n;
    score_t e_n;
    score_t diag_s;
    score_t h_n;

    assign active = LEN_W'(INDEX) < qlen;
    assign ext_w  = wide_t'({1'b0, cfg.gap_ext});
    assign oe_w   = wide_t'({1'b0, cfg.open_ext});
    assign sub_w  = (qsym_reg == tok_in.dsym[CMP_W-1:0])
                  ? wide_t'({1'b0, cfg.match}) : wide_t'(cfg.mismatch);

    // first symbol of a database sequence sees a freshly cleared column
    assign h_cur = tok_in.first ? '0 : h_reg;
    assign e_cur = tok_in.first ? -score_t'({1'b0, cfg.open_pen}) : e_reg;

    assign qgap_n = clamp16(wmax(wide_t'(tok_in.qgap) - ext_w, wide_t'(tok_in.left) - oe_w));
    assign e_n    = clamp16(wmax(wide_t'(e_cur) - ext_w, wide_t'(h_cur) - oe_w));
    assign diag_s = clamp16(wide_t'(tok_in.diag) + sub_w);
    assign h_n    = smax(smax(diag_s, '0), smax(qgap_n, e_n));

    always_comb begin
        tok_next = tok_in;
        if (active) begin
            tok_next.left = h_n;
            tok_next.qgap = qgap_n;
            tok_next.diag = h_cur;
            tok_next.best = smax(tok_in.best, h_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid && (wr_idx == LEN_W'(INDEX))) begin
            qsym_reg <= wr_sym[CMP_W-1:0];
        end
        if (advance && tok_in.valid && active) begin
            h_reg <= h_n;
            e_reg <= e_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/lasa_checker.sv =====
// Port-level checks for the alignment block, bound to the top level.
module lasa_checker import lasa_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // hold a result that has not been taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_rst_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // database transactions last only while the result side can move
    a_db_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s_tuser |-> !s_tready)
        else $error("database transaction taken while result stalled");

    a_open_rdback: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && psel && penable && pwrite && pready && (paddr[3:2] == REG_GAP_OPEN)
        |=> (paddr[3:2] != REG_GAP_OPEN) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("gap open register read back wrong");

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[M_TDATA_W-1])
        else $error("score padding bit set");

endmodule

bind local_alignment_score_affine lasa_checker u_lasa_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the affine-gap local alignment score block.
module tb_top import lasa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NQ           = MAX_QUERY_DEF;
    localparam logic [3:0]  SYM_MASK     = 4'((1 << SYMBOL_BITS_DEF) - 1);
    localparam int          DRAIN_CYCLES = NQ + 16;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          RAND_ITEMS   = 110;

    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_DB    = 1'b1;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    typedef struct packed {
        logic        db;
        logic [3:0]  sym;
        logic        last;
        logic        known;
        logic [14:0] score;
    } sym_item_t;

    typedef struct packed {
        logic        db;
        logic [3:0]  sym;
        logic [7:0]  reps;
        logic        last;
        logic        known;
        logic [14:0] score;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] gap_o;
        logic [7:0] gap_e;
        logic [6:0] mat;
        logic [7:0] mis;
    } penalty_set_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [3:0] symbol
    logic                  s_tuser  = 1'b0; // [0] req_type
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [14:0] score
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    local_alignment_score_affine DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // alignment state mirrored from the block
    logic [7:0]        pen_open  = GAP_OPEN_RST;
    logic [7:0]        pen_ext   = GAP_EXTEND_RST;
    logic [6:0]        pen_match = MATCH_RST;
    logic signed [7:0] pen_mis   = MISMATCH_RST;
    logic [3:0]        qry_sym [NQ];
    int unsigned       qry_len   = 0;
    int                cell_h [NQ];
    int                cell_e [NQ];
    int                best_h    = 0;
    bit                qry_open  = 1'b1;
    bit                row_busy  = 1'b0;

    sym_item_t   send_q[$];
    sym_item_t   track_q[$];
    logic [14:0] score_q[$];
    int          n_err    = 0;
    int          idle_cnt = 0;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int clip16(input int v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // advance the alignment by one symbol; returns 1 when a score is due
    function automatic bit sw_step(input logic is_db, input logic [3:0] sym,
                                   input logic is_last, output logic [14:0] score);
        int oe, ext, s, qgap, left, diag, h;
        oe    = int'(pen_open) + int'(pen_ext);
        ext   = int'(pen_ext);
        score = '0;
        if (is_db == REQ_QUERY) begin
            if (!qry_open) begin
                qry_len  = 0;
                qry_open = 1'b1;
                row_busy = 1'b0;
            end
            if (qry_len < NQ) begin
                qry_sym[qry_len] = sym;
                qry_len++;
            end
            if (is_last) qry_open = 1'b0;
            return 1'b0;
        end
        qry_open = 1'b0;
        if (!row_busy) begin
            for (int j = 0; j < NQ; j++) begin
                cell_h[j] = 0;
                cell_e[j] = -int'(pen_open);
            end
            best_h   = 0;
            row_busy = 1'b1;
        end
        qgap = -int'(pen_open);
        left = 0;
        diag = 0;
        for (int j = 0; j < qry_len; j++) begin
            s = ((qry_sym[j] & SYM_MASK) == (sym & SYM_MASK)) ? int'(pen_match)
                                                               : int'(pen_mis);
            qgap      = clip16(imax(qgap - ext, left - oe));
            cell_e[j] = clip16(imax(cell_e[j] - ext, cell_h[j] - oe));
            h         = imax(clip16(diag + s), 0);
            h         = imax(imax(h, qgap), cell_e[j]);
            diag      = cell_h[j];
            cell_h[j] = h;
            left      = h;
            best_h    = imax(best_h, h);
        end
        if (is_last) begin
            row_busy = 1'b0;
            score    = 15'(imax(best_h, 0));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_item(input logic db, input logic [3:0] sym,
                                     input logic last, input logic known = 1'b0,
                                     input logic [14:0] score = '0);
        sym_item_t it;
        it = '{db: db, sym: sym, last: last, known: known, score: score};
        send_q.push_back(it);
        track_q.push_back(it);
    endfunction

    function automatic logic [3:0] pick_sym(input bit narrow);
        return narrow ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    endfunction

    function automatic int pick_qlen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 12);
        if (r < 92) return $urandom_range(13, NQ);
        return $urandom_range(NQ + 1, NQ + 8);
    endfunction

    function automatic int pick_dlen();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
    endfunction

    // mostly whole query/database jobs, with abandoned and half-open sequences mixed in
    task automatic gen_random(input int target);
        int added, sel, qn, dn, nseq;
        bit narrow;
        added = 0;
        while (added < target) begin
            sel    = $urandom_range(0, 99);
            narrow = $urandom_range(0, 1);
            if (sel < 70) begin
                qn = pick_qlen();
                for (int k = 0; k < qn; k++) add_item(REQ_QUERY, pick_sym(narrow), k == qn - 1);
                added += qn;
                nseq = $urandom_range(1, 3);
                repeat (nseq) begin
                    dn = pick_dlen();
                    for (int k = 0; k < dn; k++) add_item(REQ_DB, pick_sym(narrow), k == dn - 1);
                    added += dn;
                end
            end else if (sel < 80) begin
                // query left open; the database stream closes it
                qn = $urandom_range(1, 10);
                for (int k = 0; k < qn; k++) add_item(REQ_QUERY, pick_sym(narrow), 1'b0);
                dn = pick_dlen();
                for (int k = 0; k < dn; k++) add_item(REQ_DB, pick_sym(narrow), k == dn - 1);
                added += qn + dn;
            end else if (sel < 90) begin
                dn = $urandom_range(1, 6);
                for (int k = 0; k < dn; k++) add_item(REQ_DB, pick_sym(narrow), 1'b0);
                added += dn;
            end else begin
                dn = pick_dlen();
                for (int k = 0; k < dn; k++) add_item(REQ_DB, pick_sym(narrow), k == dn - 1);
                added += dn;
            end
        end
        // close the phase so no database sequence straddles a register write
        add_item(REQ_DB, pick_sym(1'b0), 1'b1);
    endtask

    task automatic drive_items();
        sym_item_t it;
        int burst, gap;
        burst = 0;
        while (send_q.size() != 0) begin
            if (burst == 0) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            it = send_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= it.db;
            s_tdata  <= S_TDATA_W'(it.sym);
            s_tlast  <= it.last;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            @(negedge aclk);
            burst--;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [7:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= APB_DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_GAP_OPEN:   pen_open  = val;
            REG_GAP_EXTEND: pen_ext   = val;
            REG_MATCH:      pen_match = val[6:0];
            REG_MISMATCH:   pen_mis   = val;
            default:        ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        while (score_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver: stretches of open flow, coin-flip stalls, sparse acceptance and holds
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(4, 24) : $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        sym_item_t   cur;
        logic [14:0] pred;
        logic [14:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cur = track_q.pop_front();
                if (sw_step(s_tuser, s_tdata[3:0], s_tlast, pred)) begin
                    score_q.push_back(cur.known ? cur.score : pred);
                end
            end
            if (m_tvalid && m_tready) begin
                if (score_q.size() == 0) begin
                    $display("%0t: score expected none got %0d", $time, m_tdata);
                    n_err++;
                end else begin
                    want = score_q.pop_front();
                    if (m_tdata !== M_TDATA_W'(want)) begin
                        $display("%0t: score expected %0d got %0d", $time, want, m_tdata);
                        n_err++;
                    end
                end
            end
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)
            || !aresetn) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d scores outstanding",
                     $time, STALL_LIMIT, score_q.size());
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    plan_row_t    plan [0:20];
    penalty_set_t pen_sets [0:5];

    initial begin
        // typed scores hold for the reset penalties: match 10, mismatch -15
        plan = '{
            '{REQ_DB,    4'd5,  8'd1,  1'b1, 1'b1, 15'd0},   // empty query after reset
            '{REQ_QUERY, 4'd3,  8'd1,  1'b1, 1'b0, 15'd0},
            '{REQ_DB,    4'd3,  8'd1,  1'b1, 1'b1, 15'd10},  // single match
            '{REQ_DB,    4'd4,  8'd1,  1'b1, 1'b1, 15'd0},   // mismatch floors at zero
            '{REQ_QUERY, 4'd0,  8'd1,  1'b0, 1'b0, 15'd0},
            '{REQ_QUERY, 4'd15, 8'd1,  1'b1, 1'b0, 15'd0},
            '{REQ_DB,    4'd0,  8'd1,  1'b0, 1'b0, 15'd0},
            '{REQ_DB,    4'd15, 8'd1,  1'b1, 1'b0, 15'd0},
            '{REQ_QUERY, 4'd1,  8'd1,  1'b0, 1'b0, 15'd0},
            '{REQ_QUERY, 4'd2,  8'd1,  1'b1, 1'b0, 15'd0},
            '{REQ_DB,    4'd1,  8'd1,  1'b0, 1'b0, 15'd0},
            '{REQ_QUERY, 4'd7,  8'd1,  1'b1, 1'b0, 15'd0},   // abandons the open row
            '{REQ_DB,    4'd7,  8'd1,  1'b1, 1'b1, 15'd10},
            '{REQ_QUERY, 4'd9,  8'd2,  1'b0, 1'b0, 15'd0},
            '{REQ_DB,    4'd9,  8'd3,  1'b1, 1'b0, 15'd0},   // closes the open query
            '{REQ_QUERY, 4'd6,  8'd70, 1'b1, 1'b0, 15'd0},   // overlong query
            '{REQ_DB,    4'd6,  8'd4,  1'b1, 1'b0, 15'd0},
            '{REQ_DB,    4'd6,  8'd1,  1'b1, 1'b1, 15'd10},  // fresh row, same query
            '{REQ_QUERY, 4'd10, 8'd1,  1'b1, 1'b0, 15'd0},
            '{REQ_DB,    4'd10, 8'd2,  1'b0, 1'b0, 15'd0},
            '{REQ_DB,    4'd11, 8'd1,  1'b1, 1'b0, 15'd0}
        };
        pen_sets = '{
            '{8'd0,   8'd0,   7'd127, 8'd127},
            '{8'd255, 8'd255, 7'd0,   8'h80},
            '{8'd0,   8'd255, 7'd127, 8'h80},
            '{8'd255, 8'd0,   7'd1,   8'd0},
            '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))},
            '{8'($urandom_range(0, 40)), 8'($urandom_range(0, 12)),
              7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))}
        };

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < $size(plan); r++) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                add_item(plan[r].db, plan[r].sym, plan[r].last && (k == plan[r].reps - 1),
                         plan[r].known && (k == plan[r].reps - 1), plan[r].score);
            end
        end
        gen_random(RAND_ITEMS);
        drive_items();
        settle();

        foreach (pen_sets[p]) begin
            reg_write(REG_GAP_OPEN,   pen_sets[p].gap_o);
            reg_write(REG_GAP_EXTEND, pen_sets[p].gap_e);
            reg_write(REG_MATCH,      8'(pen_sets[p].mat));
            reg_write(REG_MISMATCH,   pen_sets[p].mis);
            gen_random(RAND_ITEMS);
            drive_items();
            settle();
        end

        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
